// ===== src/ungapped_diagonal_max_segment_core_defines.svh =====
// Assertion macros used by the port-level checker of the diagonal scoring core.
`ifndef UNGAPPED_DIAGONAL_MAX_SEGMENT_CORE_DEFINES_SVH
`define UNGAPPED_DIAGONAL_MAX_SEGMENT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define UDMS_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("udms check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define UDMS_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("udms check failed");

`endif

// ===== src/udms_pkg.sv =====
// Types, constants and helpers of the diagonal scoring core.
`timescale 1ns / 1ps

package udms_pkg;

  localparam int ALPHABET_SIZE = 32;
  localparam int MAX_DIAG_LEN  = 65536;

  localparam int SYM_W   = 5;
  localparam int VALUE_W = 8;
  localparam int SCORE_W = 24;
  localparam int POS_W   = 16;
  localparam int SUM_W   = SCORE_W + 2;

  localparam int TABLE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int POS_LIMIT = ((MAX_DIAG_LEN > 65536) ? 65536 : MAX_DIAG_LEN) - 1;
  localparam int SCORE_MAX = (1 << SCORE_W) - 1;

  typedef enum logic [1:0] {
    CMD_LOAD_STRUCT = 2'd0,
    CMD_LOAD_RES    = 2'd1,
    CMD_SCORE       = 2'd2
  } udms_cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [SYM_W-1:0]   table_row;
    logic [SYM_W-1:0]   table_col;
    logic signed [VALUE_W-1:0] table_value;
    logic [SYM_W-1:0]   query_struct_sym;
    logic [SYM_W-1:0]   target_struct_sym;
    logic [SYM_W-1:0]   query_res_sym;
    logic [SYM_W-1:0]   target_res_sym;
    logic               last_position;
  } udms_request_t;

  typedef struct packed {
    logic [SCORE_W-1:0] best_score;
    logic [POS_W-1:0]   best_start;
    logic [POS_W-1:0]   best_end;
  } udms_result_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic struct_oob;
    logic res_oob;
  } udms_ctrl_t;

  function automatic logic sym_oob(input logic [SYM_W-1:0] row, input logic [SYM_W-1:0] col);
    return (int'(row) >= ALPHABET_SIZE) || (int'(col) >= ALPHABET_SIZE);
  endfunction

  function automatic logic [ADDR_W-1:0] table_addr(input logic [SYM_W-1:0] row,
                                                   input logic [SYM_W-1:0] col);
    return ADDR_W'(int'(row) * ALPHABET_SIZE + int'(col));
  endfunction

endpackage

// ===== src/udms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module udms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/udms_score.sv =====
// Running-score accumulator, best-segment tracker and result register.
`timescale 1ns / 1ps

module udms_score (
  input  logic                                clk,
  input  logic                                rst,
  input  udms_pkg::udms_ctrl_t                ctrl,
  input  logic signed [udms_pkg::VALUE_W-1:0] struct_rdata,
  input  logic signed [udms_pkg::VALUE_W-1:0] res_rdata,
  input  logic                                result_stall,
  output logic                                result_valid,
  output udms_pkg::udms_result_t              result,
  output logic                                advance
);

  logic [udms_pkg::SCORE_W-1:0] running_score;
  logic [udms_pkg::SCORE_W-1:0] top_score;
  logic [udms_pkg::POS_W-1:0]   segment_start_candidate;
  logic [udms_pkg::POS_W-1:0]   top_start;
  logic [udms_pkg::POS_W-1:0]   top_end;
  logic [udms_pkg::POS_W-1:0]   position_count;

  logic signed [udms_pkg::VALUE_W-1:0] struct_val;
  logic signed [udms_pkg::VALUE_W-1:0] res_val;
  logic signed [udms_pkg::SUM_W-1:0]   sum;
  logic [udms_pkg::POS_W-1:0]          pos_inc;

  logic [udms_pkg::SCORE_W-1:0] running_score_next;
  logic [udms_pkg::SCORE_W-1:0] top_score_next;
  logic [udms_pkg::POS_W-1:0]   segment_start_candidate_next;
  logic [udms_pkg::POS_W-1:0]   top_start_next;
  logic [udms_pkg::POS_W-1:0]   top_end_next;

  assign advance = !(result_valid && result_stall);

  always_comb begin
    struct_val = ctrl.struct_oob ? '0 : struct_rdata;
    res_val    = ctrl.res_oob ? '0 : res_rdata;
    sum = $signed({2'b00, running_score}) + udms_pkg::SUM_W'(struct_val)
        + udms_pkg::SUM_W'(res_val);

    if (position_count >= udms_pkg::POS_W'(udms_pkg::POS_LIMIT)) begin
      pos_inc = udms_pkg::POS_W'(udms_pkg::POS_LIMIT);
    end else begin
      pos_inc = position_count + 1'b1;
    end

    segment_start_candidate_next = segment_start_candidate;
    if (sum[udms_pkg::SUM_W-1] || (sum == '0)) begin
      running_score_next           = '0;
      segment_start_candidate_next = pos_inc;
    end else if (sum > udms_pkg::SUM_W'(udms_pkg::SCORE_MAX)) begin
      running_score_next = udms_pkg::SCORE_W'(udms_pkg::SCORE_MAX);
    end else begin
      running_score_next = sum[udms_pkg::SCORE_W-1:0];
    end

    top_score_next = top_score;
    top_start_next = top_start;
    top_end_next   = top_end;
    if (running_score_next > top_score) begin
      top_score_next = running_score_next;
      top_start_next = segment_start_candidate_next;
      top_end_next   = position_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_score           <= '0;
      top_score               <= '0;
      segment_start_candidate <= '0;
      top_start               <= '0;
      top_end                 <= '0;
      position_count          <= '0;
    end else if (advance && ctrl.valid) begin
      if (ctrl.last) begin
        running_score           <= '0;
        top_score               <= '0;
        segment_start_candidate <= '0;
        top_start               <= '0;
        top_end                 <= '0;
        position_count          <= '0;
      end else begin
        running_score           <= running_score_next;
        top_score               <= top_score_next;
        segment_start_candidate <= segment_start_candidate_next;
        top_start               <= top_start_next;
        top_end                 <= top_end_next;
        position_count          <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= ctrl.valid && ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.best_score <= top_score_next;
      result.best_start <= top_start_next;
      result.best_end   <= top_end_next;
    end
  end

endmodule

// ===== src/ungapped_diagonal_max_segment_core.sv =====
// Top level of the ungapped diagonal maximum-scoring segment core.
// One request is taken per clock cycle, loads and scoring positions alike, for as long as
// the result side keeps up; the rate is set by the two table RAMs, each of which serves one
// write and one read per cycle, and by the add-and-clamp loop through the running-score
// register. A load writes its table entry at acceptance; a scoring request reads both
// tables at acceptance into the RAM read registers, then is folded into the running score,
// so a load may be followed directly by a position that reads the same entry. Once its last
// position is accepted, a result passes through the control register, then the result
// register. request_stall rises only while a finished result waits with result_stall high.
// The tables are not cleared after reset and must be loaded before they are read.
`timescale 1ns / 1ps

module ungapped_diagonal_max_segment_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   request_valid,
  output logic                   request_stall,
  input  udms_pkg::udms_request_t request,
  output logic                   result_valid,
  input  logic                   result_stall,
  output udms_pkg::udms_result_t result
);

  logic accept;
  logic advance;
  logic is_score;

  logic                                struct_we;
  logic                                res_we;
  logic [udms_pkg::ADDR_W-1:0]         load_addr;
  logic [udms_pkg::ADDR_W-1:0]         struct_raddr;
  logic [udms_pkg::ADDR_W-1:0]         res_raddr;
  logic signed [udms_pkg::VALUE_W-1:0] struct_rdata;
  logic signed [udms_pkg::VALUE_W-1:0] res_rdata;

  udms_pkg::udms_ctrl_t ctrl;
  udms_pkg::udms_ctrl_t ctrl_next;

  assign request_stall = !advance;
  assign accept        = request_valid && !request_stall;
  assign is_score      = request.command == udms_pkg::CMD_SCORE;

  always_comb begin
    load_addr    = udms_pkg::table_addr(request.table_row, request.table_col);
    struct_raddr = udms_pkg::table_addr(request.query_struct_sym, request.target_struct_sym);
    res_raddr    = udms_pkg::table_addr(request.query_res_sym, request.target_res_sym);
    struct_we = accept && (request.command == udms_pkg::CMD_LOAD_STRUCT)
             && !udms_pkg::sym_oob(request.table_row, request.table_col);
    res_we    = accept && (request.command == udms_pkg::CMD_LOAD_RES)
             && !udms_pkg::sym_oob(request.table_row, request.table_col);
    ctrl_next.valid      = accept && is_score;
    ctrl_next.last       = request.last_position;
    ctrl_next.struct_oob = udms_pkg::sym_oob(request.query_struct_sym,
                                             request.target_struct_sym);
    ctrl_next.res_oob    = udms_pkg::sym_oob(request.query_res_sym, request.target_res_sym);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (advance) begin
      ctrl <= ctrl_next;
    end
  end

  udms_ram #(
    .WIDTH (udms_pkg::VALUE_W),
    .DEPTH (udms_pkg::TABLE_DEPTH)
  ) u_struct_table (
    .clk   (clk),
    .we    (struct_we),
    .waddr (load_addr),
    .wdata (request.table_value),
    .re    (ctrl_next.valid),
    .raddr (struct_raddr),
    .rdata (struct_rdata)
  );

  udms_ram #(
    .WIDTH (udms_pkg::VALUE_W),
    .DEPTH (udms_pkg::TABLE_DEPTH)
  ) u_res_table (
    .clk   (clk),
    .we    (res_we),
    .waddr (load_addr),
    .wdata (request.table_value),
    .re    (ctrl_next.valid),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  udms_score u_score (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .struct_rdata (struct_rdata),
    .res_rdata    (res_rdata),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .advance      (advance)
  );

endmodule

// ===== src/udms_checker.sv =====
// Port-level checks of the diagonal scoring core and their binding to the top level.
`timescale 1ns / 1ps
`include "ungapped_diagonal_max_segment_core_defines.svh"

module udms_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   request_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input udms_pkg::udms_result_t result
);

  `UDMS_ASSERT_IMPL(stall_only_on_backpressure, request_stall, result_valid && result_stall)
  `UDMS_ASSERT_NEXT(result_held, result_valid && result_stall, result_valid)
  `UDMS_ASSERT_NEXT(result_stable, result_valid && result_stall, $stable(result))
  `UDMS_ASSERT_IMPL(start_not_after_end, result_valid, result.best_start <= result.best_end)
  `UDMS_ASSERT_IMPL(empty_segment_at_zero, result_valid && (result.best_score == '0),
                    (result.best_start == '0) && (result.best_end == '0))

endmodule

bind ungapped_diagonal_max_segment_core udms_checker u_checker (.*);
